// ===== hdl/stcf_pkg.sv =====
// Shared types and constants for the serial-to-CAN frame parser.
`default_nettype none
package stcf_pkg;

	localparam int unsigned MAX_PAYLOAD = 8;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] SYNC_RESET = 8'h66;
	localparam logic [7:0] END_RESET = 8'hEE;

	typedef enum logic [0:0] {
		CFG_SYNC = 1'b0,
		CFG_END  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_TYPE = 3'd1,
		ST_BAD_KIND = 3'd2,
		ST_BAD_LEN  = 3'd3,
		ST_BAD_END  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_sync;
		logic       is_end;
		logic       is_zero;
		logic       is_ones;
		logic       len_ok;
	} word_t;

endpackage
`default_nettype wire

// ===== hdl/stcf_front.sv =====
// Input side: accepts serial words and tags each with its byte classes.
`default_nettype none
module stcf_front (
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   rx_byte,
	input  wire logic [7:0]   sync_byte,
	input  wire logic [7:0]   end_byte,
	input  wire logic         q_full,
	output logic              push,
	output stcf_pkg::word_t   push_word
);
	import stcf_pkg::*;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_word.data = rx_byte;
		push_word.is_sync = (rx_byte == sync_byte);
		push_word.is_end = (rx_byte == end_byte);
		push_word.is_zero = (rx_byte == BYTE_ZERO);
		push_word.is_ones = (rx_byte == BYTE_ONES);
		push_word.len_ok = (rx_byte <= 8'(MAX_PAYLOAD));
	end

endmodule
`default_nettype wire

// ===== hdl/stcf_queue.sv =====
// Short shifting queue of classified words between the front and back sides.
`default_nettype none
module stcf_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stcf_pkg::word_t  push_word,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output stcf_pkg::word_t       head
);
	import stcf_pkg::*;

	word_t entry_q [QDEPTH];
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign valid = (count_q != '0);
	assign head = entry_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	for (genvar g = 0; g < QDEPTH; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (pop) begin
				if (push && (QCNT_W'(g + 1) == count_q)) begin
					entry_q[g] <= push_word;
				end else begin
					if (g < QDEPTH - 1) begin
						entry_q[g] <= entry_q[(g + 1) % QDEPTH];
					end
				end
			end else if (push && (QCNT_W'(g) == count_q)) begin
				entry_q[g] <= push_word;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/stcf_back.sv =====
// Frame parser state machine with its result register.
`default_nettype none
module stcf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire stcf_pkg::word_t  q_word,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [2:0]            status,
	output logic                  is_remote,
	output logic                  is_extended,
	output logic [31:0]           frame_id,
	output logic [3:0]            payload_len,
	output logic [63:0]           payload
);
	import stcf_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_TYPE = 3'd1,
		PH_KIND = 3'd2,
		PH_ID   = 3'd3,
		PH_LEN  = 3'd4,
		PH_DATA = 3'd5,
		PH_END  = 3'd6
	} phase_t;

	phase_t phase_q;
	logic remote_q;
	logic ext_q;
	logic [31:0] id_q;
	logic [3:0] left_q;
	logic [3:0] len_q;
	logic [63:0] pay_q;

	logic out_valid_q;
	status_t status_q;
	logic is_remote_q;
	logic is_extended_q;
	logic [31:0] frame_id_q;
	logic [3:0] payload_len_q;
	logic [63:0] payload_q;

	logic emits;
	logic load;
	logic good;
	logic [3:0] left_dec;
	logic [3:0] pos_full;
	logic [2:0] pos;

	always_comb begin
		case (phase_q)
			PH_TYPE: emits = !q_word.is_zero && !q_word.is_ones;
			PH_KIND: emits = !q_word.is_zero && !q_word.is_ones;
			PH_LEN:  emits = !q_word.len_ok;
			PH_END:  emits = 1'b1;
			default: emits = 1'b0;
		endcase
	end

	assign q_pop = q_valid && (!emits || !out_valid_q || !out_stall);
	assign load = q_pop && emits;
	assign good = (phase_q == PH_END) && q_word.is_end;
	assign left_dec = left_q - 4'd1;
	assign pos_full = len_q - left_q;
	assign pos = pos_full[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			remote_q <= 1'b0;
			ext_q <= 1'b0;
			id_q <= '0;
			left_q <= '0;
			len_q <= '0;
			pay_q <= '0;
		end else if (q_pop) begin
			case (phase_q)
				PH_TYPE: begin
					if (q_word.is_zero) begin
						remote_q <= 1'b0;
						phase_q <= PH_KIND;
					end else if (q_word.is_ones) begin
						remote_q <= 1'b1;
						phase_q <= PH_KIND;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_KIND: begin
					if (q_word.is_zero || q_word.is_ones) begin
						ext_q <= q_word.is_ones;
						left_q <= q_word.is_ones ? 4'd4 : 4'd2;
						id_q <= '0;
						phase_q <= PH_ID;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_ID: begin
					id_q <= {id_q[23:0], q_word.data};
					left_q <= left_dec;
					if (left_dec == 4'd0) begin
						phase_q <= remote_q ? PH_END : PH_LEN;
					end
				end
				PH_LEN: begin
					if (q_word.len_ok) begin
						len_q <= q_word.data[3:0];
						left_q <= q_word.data[3:0];
						pay_q <= '0;
						phase_q <= (q_word.data[3:0] == 4'd0) ? PH_END : PH_DATA;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_DATA: begin
					for (int i = 0; i < 8; i++) begin
						if (pos == 3'(i)) begin
							pay_q[i*8 +: 8] <= pay_q[i*8 +: 8] | q_word.data;
						end
					end
					left_q <= left_dec;
					if (left_dec == 4'd0) begin
						phase_q <= PH_END;
					end
				end
				PH_END: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					if (q_word.is_sync) begin
						remote_q <= 1'b0;
						ext_q <= 1'b0;
						id_q <= '0;
						left_q <= '0;
						len_q <= '0;
						pay_q <= '0;
						phase_q <= PH_TYPE;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			case (phase_q)
				PH_TYPE: status_q <= ST_BAD_TYPE;
				PH_KIND: status_q <= ST_BAD_KIND;
				PH_LEN:  status_q <= ST_BAD_LEN;
				default: status_q <= q_word.is_end ? ST_OK : ST_BAD_END;
			endcase
			is_remote_q <= good && remote_q;
			is_extended_q <= good && ext_q;
			frame_id_q <= good ? id_q : 32'd0;
			payload_len_q <= (good && !remote_q) ? len_q : 4'd0;
			payload_q <= (good && !remote_q) ? pay_q : 64'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign is_remote = is_remote_q;
	assign is_extended = is_extended_q;
	assign frame_id = frame_id_q;
	assign payload_len = payload_len_q;
	assign payload = payload_q;

endmodule
`default_nettype wire

// ===== hdl/serial_to_can_frame_parser.sv =====
// Top level of the serial-to-CAN frame parser: configuration registers and wiring.
//
//   Channel   Direction  Handshake               Word
//   input     in         in_valid / in_stall     rx_byte
//   result    out        out_valid / out_stall   status, is_remote, is_extended,
//                                                frame_id, payload_len, payload
//   config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is taken every cycle while the four-word queue has room.
// A byte is parsed at the edge on which it is popped from the head of the queue, and that
// same edge loads the result register when the byte produces a result.
// The parser stalls only on a byte that produces a result while the result register
// still holds a stalled word.
// Reset clears the queue, the parse state and the result valid flag at once.
`default_nettype none
module serial_to_can_frame_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [2:0]        status,
	output logic              is_remote,
	output logic              is_extended,
	output logic [31:0]       frame_id,
	output logic [3:0]        payload_len,
	output logic [63:0]       payload,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [7:0]   cfg_data
);
	import stcf_pkg::*;

	logic [7:0] sync_q;
	logic [7:0] end_q;
	logic q_full;
	logic q_push;
	word_t push_word;
	logic q_pop;
	logic q_valid;
	word_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
			end_q <= END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SYNC: sync_q <= cfg_data;
				CFG_END:  end_q <= cfg_data;
				default:  sync_q <= sync_q;
			endcase
		end
	end

	stcf_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.sync_byte (sync_q),
		.end_byte  (end_q),
		.q_full    (q_full),
		.push      (q_push),
		.push_word (push_word)
	);

	stcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	stcf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_word      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.is_remote   (is_remote),
		.is_extended (is_extended),
		.frame_id    (frame_id),
		.payload_len (payload_len),
		.payload     (payload)
	);

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (frame_id == '0) && (payload == '0)
			&& (payload_len == '0) && !is_remote && !is_extended)
		else $error("Error result carries frame fields.");

	a_remote_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_remote |-> (payload_len == '0) && (payload == '0))
		else $error("Remote frame result carries payload.");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> payload_len <= 4'(MAX_PAYLOAD))
		else $error("Payload length above limit.");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> q_valid)
		else $error("Queue full without a head word.");

endmodule
`default_nettype wire
